/* rtl/ugis_pkg.sv */
package ugis_pkg;

    // table geometry
    localparam int INDEX_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(INDEX_DEPTH);
    localparam int CNT_W       = $clog2(INDEX_DEPTH + 1);
    localparam int ENTRY_W     = 64;

    // field widths
    localparam int KEY_W     = 32;
    localparam int OFFSET_W  = 32;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_BASE = 2'd2;

    // utf-8 lead byte patterns
    localparam logic [7:0] LEAD_ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD_TWO_MASK   = 8'hE0;
    localparam logic [7:0] LEAD_TWO_VAL    = 8'hC0;
    localparam logic [7:0] LEAD_THREE_MASK = 8'hF0;
    localparam logic [7:0] LEAD_THREE_VAL  = 8'hE0;
    localparam logic [7:0] LEAD_FOUR_MASK  = 8'hF8;
    localparam logic [7:0] LEAD_FOUR_VAL   = 8'hF0;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   entry_slot;
        logic [KEY_W-1:0]    entry_key;
        logic [OFFSET_W-1:0] entry_glyph_offset;
        logic [KEY_W-1:0]    char_bytes;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] bitmap_address;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_REPLY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write;
        logic probe;
        logic check;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_write;
        logic is_bad;
        logic open;
        logic hit;
        logic out_busy;
    } stat_t;

    // byte count from the lead byte, zero when the lead byte is illegal
    function automatic logic [2:0] lead_length(input logic [7:0] lead);
        if ((lead & LEAD_ASCII_MASK) == 8'h00) return 3'd1;
        if ((lead & LEAD_TWO_MASK) == LEAD_TWO_VAL) return 3'd2;
        if ((lead & LEAD_THREE_MASK) == LEAD_THREE_VAL) return 3'd3;
        if ((lead & LEAD_FOUR_MASK) == LEAD_FOUR_VAL) return 3'd4;
        return 3'd0;
    endfunction

    // illegal lead byte or a zero byte inside the character
    function automatic logic char_invalid(input logic [KEY_W-1:0] b);
        logic [2:0] len;
        len = lead_length(b[31:24]);
        return (len == 3'd0) || (b[31:24] == 8'h00)
            || ((len >= 3'd2) && (b[23:16] == 8'h00))
            || ((len >= 3'd3) && (b[15:8] == 8'h00))
            || ((len == 3'd4) && (b[7:0] == 8'h00));
    endfunction

    // keep the bytes of the character, zero the rest
    function automatic logic [KEY_W-1:0] char_key(input logic [KEY_W-1:0] b);
        logic [2:0] len;
        len = lead_length(b[31:24]);
        case (len)
            3'd1:    return {b[31:24], 24'h000000};
            3'd2:    return {b[31:16], 16'h0000};
            3'd3:    return {b[31:8], 8'h00};
            3'd4:    return b;
            default: return '0;
        endcase
    endfunction

endpackage

/* rtl/ugis_ram.sv */
module ugis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

/* rtl/ugis_ctrl.sv */
module ugis_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    output ugis_pkg::cmd_t   cmd,
    input  ugis_pkg::stat_t  stat
);

    ugis_pkg::state_t state_reg;
    ugis_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ugis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ugis_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ugis_pkg::ST_PROBE;
                end
            end
            ugis_pkg::ST_PROBE:
            begin
                if (stat.is_write || stat.is_bad || !stat.open)
                begin
                    state_next = ugis_pkg::ST_REPLY;
                end
                else
                begin
                    state_next = ugis_pkg::ST_CHECK;
                end
            end
            ugis_pkg::ST_CHECK:
            begin
                if (stat.hit)
                begin
                    state_next = ugis_pkg::ST_REPLY;
                end
                else
                begin
                    state_next = ugis_pkg::ST_PROBE;
                end
            end
            ugis_pkg::ST_REPLY:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ugis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ugis_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ugis_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            ugis_pkg::ST_PROBE:
            begin
                cmd.write = stat.is_write;
                cmd.probe = !stat.is_write && !stat.is_bad && stat.open;
            end
            ugis_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ugis_pkg::ST_REPLY:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // a compare always follows the read that feeds it
    a_check_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ugis_pkg::ST_CHECK) |-> ($past(state_reg) == ugis_pkg::ST_PROBE))
        else $error("compare without a preceding table read");

    // a match ends the search
    a_hit_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ugis_pkg::ST_CHECK && stat.hit) |=> (state_reg == ugis_pkg::ST_REPLY))
        else $error("search continued after a match");
`endif

endmodule

/* rtl/ugis_dp.sv */
module ugis_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ugis_pkg::in_beat_t              item,
    input  ugis_pkg::cmd_t                  cmd,
    output ugis_pkg::stat_t                 stat,
    output logic                            result_valid,
    input  logic                            result_stall,
    output ugis_pkg::out_beat_t             result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ugis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ugis_pkg::CFG_W-1:0]      cfg_data
);

    // configuration
    logic [ugis_pkg::COUNT_W-1:0]  entry_count_reg;
    logic                          sorted_mode_reg;
    logic [ugis_pkg::OFFSET_W-1:0] bitmap_base_reg;

    // current item and search window [lo, hi)
    ugis_pkg::in_beat_t            item_reg;
    logic [ugis_pkg::KEY_W-1:0]    key_reg;
    logic                          bad_reg;
    logic [ugis_pkg::CNT_W-1:0]    lo_reg;
    logic [ugis_pkg::CNT_W-1:0]    hi_reg;
    logic                          found_reg;
    logic [ugis_pkg::OFFSET_W-1:0] offset_reg;

    // result register
    logic                          out_valid_reg;
    ugis_pkg::out_beat_t           out_reg;

    logic [31:0]                   count_ext;
    logic [ugis_pkg::CNT_W-1:0]    count_clamp;
    logic [ugis_pkg::CNT_W:0]      mid_sum;
    logic [ugis_pkg::CNT_W-1:0]    mid;
    logic [ugis_pkg::CNT_W-1:0]    probe_idx;
    logic                          slot_ok;
    logic [ugis_pkg::ENTRY_W-1:0]  rd_data;
    logic [ugis_pkg::KEY_W-1:0]    rd_key;
    logic [ugis_pkg::OFFSET_W-1:0] rd_offset;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            sorted_mode_reg <= 1'b0;
            bitmap_base_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ugis_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[ugis_pkg::COUNT_W-1:0];
                ugis_pkg::CFG_SORTED_MODE: sorted_mode_reg <= cfg_data[0];
                ugis_pkg::CFG_BITMAP_BASE: bitmap_base_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // entry count limited to the table
    assign count_ext   = 32'(entry_count_reg);
    assign count_clamp = (count_ext > 32'(ugis_pkg::INDEX_DEPTH))
                       ? ugis_pkg::CNT_W'(ugis_pkg::INDEX_DEPTH)
                       : ugis_pkg::CNT_W'(count_ext);

    // probe slot: midpoint in sorted mode, next slot in a scan
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - 1'b1;
    assign mid       = mid_sum[ugis_pkg::CNT_W:1];
    assign probe_idx = sorted_mode_reg ? mid : lo_reg;

    assign slot_ok   = 32'(item_reg.entry_slot) < 32'(ugis_pkg::INDEX_DEPTH);
    assign rd_key    = rd_data[ugis_pkg::ENTRY_W-1:ugis_pkg::OFFSET_W];
    assign rd_offset = rd_data[ugis_pkg::OFFSET_W-1:0];

    // key and offset table
    ugis_ram #(
        .WIDTH (ugis_pkg::ENTRY_W),
        .DEPTH (ugis_pkg::INDEX_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.write && slot_ok),
        .wr_addr (ugis_pkg::ADDR_W'(item_reg.entry_slot)),
        .wr_data ({item_reg.entry_key, item_reg.entry_glyph_offset}),
        .rd_en   (cmd.probe),
        .rd_addr (probe_idx[ugis_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // search window and match flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg    <= '0;
            hi_reg    <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            lo_reg    <= '0;
            hi_reg    <= count_clamp;
            found_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            if (rd_key == key_reg)
            begin
                found_reg <= 1'b1;
            end
            else if (!sorted_mode_reg)
            begin
                lo_reg <= lo_reg + 1'b1;
            end
            else if (key_reg < rd_key)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + 1'b1;
            end
        end
    end

    // item payload and matched offset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            key_reg  <= ugis_pkg::char_key(item.char_bytes);
            bad_reg  <= ugis_pkg::char_invalid(item.char_bytes);
        end
        if (cmd.check && (rd_key == key_reg))
        begin
            offset_reg <= rd_offset;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (item_reg.kind == ugis_pkg::KIND_WRITE)
            begin
                out_reg.status         <= ugis_pkg::STATUS_OK;
                out_reg.bitmap_address <= '0;
            end
            else if (bad_reg)
            begin
                out_reg.status         <= ugis_pkg::STATUS_BAD;
                out_reg.bitmap_address <= '0;
            end
            else if (found_reg)
            begin
                out_reg.status         <= ugis_pkg::STATUS_OK;
                out_reg.bitmap_address <= bitmap_base_reg + offset_reg;
            end
            else
            begin
                out_reg.status         <= ugis_pkg::STATUS_MISS;
                out_reg.bitmap_address <= '0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // status to the controller
    assign stat.is_write = (item_reg.kind == ugis_pkg::KIND_WRITE);
    assign stat.is_bad   = bad_reg;
    assign stat.open     = (lo_reg < hi_reg);
    assign stat.hit      = (rd_key == key_reg);
    assign stat.out_busy = out_valid_reg && result_stall;

`ifndef ASSERT_OFF
    // the search window never inverts
    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    // a match only ever belongs to a valid lookup
    a_found_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && cmd.finish) |-> ((item_reg.kind == ugis_pkg::KIND_LOOKUP) && !bad_reg))
        else $error("match recorded for a write or an invalid character");
`endif

endmodule

/* rtl/utf8_glyph_index_search.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------
// item     | item_valid / item_stall    | item (in_beat_t)
// result   | result_valid / result_stall| result (out_beat_t)
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// a write item or an illegal character passes the idle, probe and reply steps; a lookup adds a probe and a check step
// per table probe (a hit skips the last probe step), each probe a table RAM read and a compare.
// sorted mode: up to 11 probes for 1024 entries;
// scan mode: up to entry_count probes, capped at the table size.
// reset clears the registers and the control; the table stays unknown until written.
// the result sits in an output register, so a stalled result holds only the reply step.
module utf8_glyph_index_search (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  ugis_pkg::in_beat_t              item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output ugis_pkg::out_beat_t             result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ugis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ugis_pkg::CFG_W-1:0]      cfg_data
);

    ugis_pkg::cmd_t  cmd;
    ugis_pkg::stat_t stat;

    // sequencer
    ugis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .stat       (stat)
    );

    // table, search window and result register
    ugis_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

/* tb/sv/glyph_search_checker.sv */
module glyph_search_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  ugis_pkg::in_beat_t              item,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  ugis_pkg::out_beat_t             result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [ugis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ugis_pkg::CFG_W-1:0]      cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              checked
);

    import ugis_pkg::*;

    // mirror of the glyph table and the registers
    logic [KEY_W-1:0]    key_mem [INDEX_DEPTH];
    logic [OFFSET_W-1:0] off_mem [INDEX_DEPTH];
    logic [COUNT_W-1:0]  count_reg;
    logic                sorted_reg;
    logic [CFG_W-1:0]    base_reg;
    out_beat_t           expected_glyphs [$];
    int                  err_total;
    int                  seen_total;

    // byte count of a utf-8 character from its lead byte, zero when illegal
    function automatic int utf8_bytes(input logic [7:0] lead);
        casez (lead)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    // slot that holds the key within the searched range, -1 when absent
    function automatic int find_slot(input logic [KEY_W-1:0] key);
        int span;
        int lo;
        int hi;
        int mid;
        span = (count_reg > INDEX_DEPTH) ? INDEX_DEPTH : int'(count_reg);
        if (sorted_reg)
        begin
            lo = 0;
            hi = span - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (key_mem[mid] == key)
                    return mid;
                if (key < key_mem[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return -1;
        end
        for (int i = 0; i < span; i++)
        begin
            if (key_mem[i] == key)
                return i;
        end
        return -1;
    endfunction

    // result that one input beat should give
    function automatic out_beat_t predict_glyph(input in_beat_t b);
        out_beat_t        r;
        logic [KEY_W-1:0] key;
        logic             bad;
        int               len;
        int               hit;
        r.status = STATUS_OK;
        r.bitmap_address = '0;
        if (b.kind == KIND_LOOKUP)
        begin
            len = utf8_bytes(b.char_bytes[31:24]);
            bad = (len == 0);
            key = '0;
            for (int i = 0; i < len; i++)
            begin
                if (b.char_bytes[31-8*i -: 8] == 8'h00)
                    bad = 1'b1;
                key[31-8*i -: 8] = b.char_bytes[31-8*i -: 8];
            end
            if (bad)
                r.status = STATUS_BAD;
            else
            begin
                hit = find_slot(key);
                if (hit < 0)
                    r.status = STATUS_MISS;
                else
                    r.bitmap_address = base_reg + off_mem[hit];
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            count_reg = '0;
            sorted_reg = 1'b0;
            base_reg = '0;
            expected_glyphs.delete();
            err_total = 0;
            seen_total = 0;
            pending <= 0;
            mismatches <= 0;
            checked <= 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENTRY_COUNT: count_reg = cfg_data[COUNT_W-1:0];
                    CFG_SORTED_MODE: sorted_reg = cfg_data[0];
                    CFG_BITMAP_BASE: base_reg = cfg_data;
                    default: ;
                endcase
            end

            // result beat against the oldest expectation
            if (result_valid && !result_stall)
            begin
                seen_total++;
                if (expected_glyphs.size() == 0)
                begin
                    err_total++;
                    if (err_total <= 10)
                        $display("%0t: result beat with nothing expected: status %0d addr %h",
                                 $time, result.status, result.bitmap_address);
                end
                else
                begin
                    want = expected_glyphs.pop_front();
                    if (result.status !== want.status ||
                        result.bitmap_address !== want.bitmap_address)
                    begin
                        err_total++;
                        if (err_total <= 10)
                            $display("%0t: mismatch: status exp %0d got %0d, addr exp %h got %h",
                                     $time, want.status, result.status,
                                     want.bitmap_address, result.bitmap_address);
                    end
                end
            end

            // item beat: predict, then apply a table write
            if (item_valid && !item_stall)
            begin
                expected_glyphs.push_back(predict_glyph(item));
                if (item.kind == KIND_WRITE)
                begin
                    key_mem[item.entry_slot] = item.entry_key;
                    off_mem[item.entry_slot] = item.entry_glyph_offset;
                end
            end

            pending <= expected_glyphs.size();
            mismatches <= err_total;
            checked <= seen_total;
        end
    end

endmodule

/* tb/sv/tb.sv */
module tb;

    import ugis_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    in_beat_t             item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    out_beat_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int mismatches;
    int pending;
    int checked;

    int gap_pct = 20;
    int stall_pct = 20;
    int stall_left = 0;
    int cycles = 0;
    int items_sent = 0;
    int lookups_sent = 0;
    int reg_writes = 0;
    int settings = 0;
    int span = 0;

    // stimulus-side copy of the table keys and of the slots written so far
    logic [KEY_W-1:0] slot_key [INDEX_DEPTH];
    bit               slot_used [INDEX_DEPTH];
    logic [KEY_W-1:0] new_keys [INDEX_DEPTH];

    utf8_glyph_index_search uut (.*);

    glyph_search_checker chk (.*);

    always #6 clk = ~clk;

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL utf8_glyph_index_search");
            $finish;
        end
    end

    // result back-pressure in runs of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(2, 0);
        end
    end

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // well-formed utf-8 key, bytes past the character length zero
    function automatic logic [KEY_W-1:0] rand_glyph();
        logic [KEY_W-1:0] k;
        int               len;
        len = $urandom_range(4, 1);
        k = '0;
        case (len)
            1:       k[31:24] = 8'($urandom_range(127, 1));
            2:       k[31:24] = 8'hC0 | 8'($urandom_range(31, 0));
            3:       k[31:24] = 8'hE0 | 8'($urandom_range(15, 0));
            default: k[31:24] = 8'hF0 | 8'($urandom_range(7, 0));
        endcase
        for (int i = 1; i < len; i++)
            k[31-8*i -: 8] = 8'($urandom_range(255, 1));
        return k;
    endfunction

    // garbage in the zero tail, which the block must drop
    function automatic logic [KEY_W-1:0] add_tail(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] c;
        c = k;
        for (int i = 3; i >= 1; i--)
        begin
            if (k[31-8*i -: 8] != 8'h00)
                break;
            c[31-8*i -: 8] = 8'($urandom());
        end
        return c;
    endfunction

    function automatic int written_prefix();
        int k;
        k = 0;
        while (k < INDEX_DEPTH && slot_used[k])
            k++;
        return k;
    endfunction

    // one item beat, after a random gap
    task automatic send_beat(input in_beat_t b);
        int gap;
        gap = pick_gap(gap_pct);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= b;
        do @(posedge clk); while (item_stall);
        items_sent++;
        if (b.kind == KIND_LOOKUP)
            lookups_sent++;
    endtask

    task automatic write_entry(input int slot, input logic [KEY_W-1:0] key,
                               input logic [OFFSET_W-1:0] off);
        in_beat_t b;
        b.kind = KIND_WRITE;
        b.entry_slot = slot[SLOT_W-1:0];
        b.entry_key = key;
        b.entry_glyph_offset = off;
        b.char_bytes = $urandom();
        send_beat(b);
        slot_key[slot] = key;
        slot_used[slot] = 1'b1;
    endtask

    task automatic look_up(input logic [KEY_W-1:0] chars);
        in_beat_t b;
        b.kind = KIND_LOOKUP;
        b.entry_slot = SLOT_W'($urandom());
        b.entry_key = $urandom();
        b.entry_glyph_offset = $urandom();
        b.char_bytes = chars;
        send_beat(b);
    endtask

    // wait until the block has answered everything
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // all three registers, unused upper bits of the narrow ones randomized
    task automatic configure(input int cnt, input bit sorted, input logic [CFG_W-1:0] base);
        logic [CFG_W-1:0] raw;
        settle();
        raw = $urandom();
        raw[COUNT_W-1:0] = cnt[COUNT_W-1:0];
        write_reg(CFG_ENTRY_COUNT, raw);
        raw = $urandom();
        raw[0] = sorted;
        write_reg(CFG_SORTED_MODE, raw);
        write_reg(CFG_BITMAP_BASE, base);
        span = (cnt > INDEX_DEPTH) ? INDEX_DEPTH : cnt;
        settings++;
    endtask

    // fresh keys into slots 0 to n-1, ascending when asked
    task automatic load_table(input int n, input bit in_order);
        logic [KEY_W-1:0] t;
        int               j;
        for (int i = 0; i < n; i++)
            new_keys[i] = rand_glyph();
        if (in_order)
        begin
            for (int i = 1; i < n; i++)
            begin
                t = new_keys[i];
                j = i - 1;
                while (j >= 0 && new_keys[j] > t)
                begin
                    new_keys[j+1] = new_keys[j];
                    j--;
                end
                new_keys[j+1] = t;
            end
        end
        for (int i = 0; i < n; i++)
            write_entry(i, new_keys[i], $urandom());
    endtask

    // mostly keys in the searched range, then misses, broken and raw bytes
    task automatic random_lookup();
        logic [KEY_W-1:0] c;
        int               pick;
        int               p;
        pick = $urandom_range(99);
        p = $urandom_range(3, 0);
        if (span > 0 && pick < 65)
            c = add_tail(slot_key[$urandom_range(span - 1, 0)]);
        else if (pick < 80)
        begin
            c = rand_glyph();
            c[31-8*p -: 8] = 8'h00;
        end
        else if (pick < 90)
            c = add_tail(rand_glyph());
        else
            c = $urandom();
        look_up(c);
    endtask

    // a well-formed key already in slots 0 to n-1, so a scan stops there, or an illegal lead
    task automatic early_hit_lookup(input int n);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] c;
        k = slot_key[$urandom_range(n - 1, 0)];
        if (!char_invalid(k) && (char_key(k) == k) && ($urandom_range(3) != 0))
            c = add_tail(k);
        else
        begin
            c = $urandom();
            c[31:27] = 5'b11111;
        end
        look_up(c);
    endtask

    // write to any slot: new offset for a known key, or a new key
    task automatic random_write();
        int s;
        s = $urandom_range(INDEX_DEPTH - 1, 0);
        if (slot_used[s] && $urandom_range(1) == 1)
            write_entry(s, slot_key[s], $urandom());
        else
            write_entry(s, ($urandom_range(3) == 0) ? $urandom() : rand_glyph(), $urandom());
    endtask

    initial
    begin
        int               n;
        int               cnt;
        bit               in_order;
        bit               mode;
        logic [CFG_W-1:0] base;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: nothing searched, every character misses or is illegal
        configure(0, 1'b1, 32'h0);
        write_reg(CFG_SPARE, $urandom());
        look_up(32'h41000000);
        look_up(32'h80414243);
        look_up(32'hF8808080);
        look_up(32'hFFFFFFFF);
        look_up(32'h00000000);

        // small sorted table with every character length and offset extremes
        write_entry(0, 32'h01000000, 32'h00000000);
        write_entry(1, 32'h41000000, 32'hFFFFFFFF);
        write_entry(2, 32'h7F000000, 32'h00000010);
        write_entry(3, 32'hC3A90000, 32'h12345678);
        write_entry(4, 32'hDFBF0000, 32'h0000000F);
        write_entry(5, 32'hE282AC00, 32'h80000000);
        write_entry(6, 32'hF09F9880, 32'h7FFFFFFF);
        write_entry(7, 32'hF48FBFBF, 32'h00000001);
        write_entry(INDEX_DEPTH - 1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        configure(8, 1'b1, 32'hFFFFFFF0);
        look_up(32'h01FFFFFF);
        look_up(32'h41ABCDEF);
        look_up(32'hC3A9FFFF);
        look_up(32'hE282ACFF);
        look_up(32'hF09F9880);
        look_up(32'hF48FBFBF);
        look_up(32'hC3000000);
        look_up(32'hE2820011);
        look_up(32'hF09F9800);
        look_up(32'h42000000);
        configure(8, 1'b0, 32'h0);
        look_up(32'hF48FBFBF);
        look_up(32'h01000000);

        // random settings over small tables, idle profile changes per setting
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph % 3)
                0:
                begin
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    gap_pct = 25;
                    stall_pct <= 25;
                end
                default:
                begin
                    gap_pct = 60;
                    stall_pct <= 50;
                end
            endcase
            n = ($urandom_range(3) == 0) ? $urandom_range(120, 17) : $urandom_range(16, 1);
            in_order = ($urandom_range(4) != 0);
            mode = in_order ? ($urandom_range(5) != 0) : ($urandom_range(5) == 0);
            load_table(n, in_order);
            cnt = ($urandom_range(3) == 0) ? $urandom_range(written_prefix(), 0) : n;
            case ($urandom_range(2))
                0:       base = 32'h0;
                1:       base = 32'hFFFFFFFF;
                default: base = $urandom();
            endcase
            configure(cnt, mode, base);
            repeat (40)
            begin
                if ($urandom_range(9) == 0)
                    random_write();
                else
                    random_lookup();
            end
        end

        // count past the table size in scan mode: only early hits and illegal characters
        gap_pct = 10;
        stall_pct <= 10;
        n = written_prefix();
        configure(2047, 1'b0, 32'hFFFFFFFF);
        repeat (16) early_hit_lookup(n);

        settle();
        repeat (16) @(posedge clk);
        $display("ran %0d item beats (%0d lookups) under %0d register settings, %0d register writes",
                 items_sent, lookups_sent, settings, reg_writes);
        $display("compared %0d result beats, %0d mismatches", checked, mismatches);
        if (mismatches == 0)
            $display("PASS utf8_glyph_index_search");
        else
            $display("FAIL utf8_glyph_index_search");
        $finish;
    end

endmodule

/* files.f */
rtl/ugis_pkg.sv
rtl/ugis_ram.sv
rtl/ugis_ctrl.sv
rtl/ugis_dp.sv
rtl/utf8_glyph_index_search.sv
tb/sv/glyph_search_checker.sv
tb/sv/tb.sv
